FILE: sv/piecewise_linear_calibration_macros.svh
// Assertion macros shared by the calibration RTL.
`ifndef PIECEWISE_LINEAR_CALIBRATION_MACROS_SVH
`define PIECEWISE_LINEAR_CALIBRATION_MACROS_SVH

// Same-cycle implication, held off during reset.
`define PLC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define PLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/plc_pkg.sv
// Package: constants, opcodes and sequencer states for the calibration block.
`timescale 1ns / 1ps
package plc_pkg;

    localparam int POINTS_DEF = 8;
    localparam int DW         = 32;
    localparam int QW         = 34;  // quotient bits kept; larger quotients saturate
    localparam int DIV_STEPS  = QW;

    localparam logic OP_MAP  = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK0,
        S_CHKN,
        S_SCAN,
        S_FETCH,
        S_FETCH2,
        S_MUL,
        S_DIVI,
        S_DIV,
        S_FIN,
        S_OUT
    } plc_state_t;

endpackage

FILE: sv/piecewise_linear_calibration.sv
// A load word gives its result word in the cycle after acceptance; a map word passes at most
// through a segment search over one comparator (CHK0, CHKN, SCAN), two fetch states,
// one 32x32 multiply, divider setup, 34 divide steps and a clamp state, in that order.
// One word in flight: in_ready returns the cycle after the result is taken, so no new
// word is accepted while a load or map word is in progress or its result is stalled.
// Reset (rst_n low, asynchronous) clears the sequencer and all breakpoints to zero.
`timescale 1ns / 1ps
module piecewise_linear_calibration #(
    parameter int POINTS = plc_pkg::POINTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                opcode,
    input  logic [2:0]          point_index,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  sample,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  calibrated_value,
    output logic                divide_fault,
    output logic                saturated
);
    import plc_pkg::*;
    `include "piecewise_linear_calibration_macros.svh"

    localparam int AW = $clog2(POINTS);
    localparam logic [AW-1:0] LAST     = AW'(POINTS - 1);
    localparam logic [AW-1:0] SEG_LAST = AW'(POINTS - 2);
    localparam logic [AW-1:0] ONE      = AW'(1);
    localparam logic [5:0]    DIV_LAST = 6'(DIV_STEPS - 1);
    localparam logic [QW-1:0] Q_LIMIT  = QW'(64'h2_0000_0000);

    plc_state_t state_reg, state_next;

    logic signed [DW-1:0] bp_x_reg [POINTS];
    logic signed [DW-1:0] bp_y_reg [POINTS];

    logic [AW-1:0]        addr_reg, addr_next;
    logic signed [DW-1:0] s_reg, s_next;
    logic signed [DW-1:0] x1_reg, x1_next;
    logic signed [DW-1:0] y1_reg, y1_next;
    logic                 neg_reg, neg_next;
    logic [DW-1:0]        dsx_mag_reg, dsx_mag_next;
    logic [DW-1:0]        dy_mag_reg, dy_mag_next;
    logic [DW-1:0]        dx_mag_reg, dx_mag_next;
    logic [2*DW-1:0]      prod_reg, prod_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [QW-1:0]        dq_reg, dq_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic                 big_reg, big_next;
    logic signed [DW-1:0] value_reg, value_next;
    logic                 fault_reg, fault_next;
    logic                 sat_reg, sat_next;

    logic                 accept;
    logic                 load_en;
    logic [AW-1:0]        wr_addr;
    logic signed [DW-1:0] x_rd, y_rd;
    logic signed [DW-1:0] cmp_a, cmp_b;
    logic                 cmp_lt;
    logic signed [DW:0]   dsx, dy, dx;
    logic [DW:0]          trial;
    logic [DW+1:0]        diff;
    logic                 ge;
    logic signed [DW+3:0] sum;
    logic                 q_big;

    assign accept  = in_valid && in_ready;
    assign load_en = accept && (opcode == OP_LOAD) && (int'(point_index) < POINTS);
    assign wr_addr = AW'(point_index);
    assign x_rd    = bp_x_reg[addr_reg];
    assign y_rd    = bp_y_reg[addr_reg];

    // Shared signed comparator: CHK0 tests x0 < s, the other states s < x.
    always_comb
    begin
        if (state_reg == S_CHK0)
        begin
            cmp_a = x_rd;
            cmp_b = s_reg;
        end
        else
        begin
            cmp_a = s_reg;
            cmp_b = x_rd;
        end
    end
    assign cmp_lt = cmp_a < cmp_b;

    assign dsx = {s_reg[DW-1], s_reg} - {x1_reg[DW-1], x1_reg};
    assign dy  = {y_rd[DW-1], y_rd} - {y1_reg[DW-1], y1_reg};
    assign dx  = {x_rd[DW-1], x_rd} - {x1_reg[DW-1], x1_reg};

    // Restoring divide step: one quotient bit per cycle.
    assign trial = {rem_reg, dq_reg[QW-1]};
    assign diff  = {1'b0, trial} - {2'b00, dx_mag_reg};
    assign ge    = !diff[DW+1];

    assign q_big = big_reg || (dq_reg > Q_LIMIT);
    assign sum   = neg_reg ? ({{4{y1_reg[DW-1]}}, y1_reg} - {2'b00, dq_reg})
                           : ({{4{y1_reg[DW-1]}}, y1_reg} + {2'b00, dq_reg});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (opcode == OP_LOAD) ? S_OUT : S_CHK0;
            end
            S_CHK0:   state_next = cmp_lt ? S_CHKN : S_FETCH;
            S_CHKN:   state_next = cmp_lt ? S_SCAN : S_FETCH;
            S_SCAN:
            begin
                if (cmp_lt || addr_reg == LAST)
                    state_next = S_FETCH;
            end
            S_FETCH:  state_next = S_FETCH2;
            S_FETCH2: state_next = (x_rd == x1_reg) ? S_OUT : S_MUL;
            S_MUL:    state_next = S_DIVI;
            S_DIVI:   state_next = ({2'b00, prod_reg[2*DW-1:QW]} >= dx_mag_reg) ? S_FIN : S_DIV;
            S_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = S_FIN;
            end
            S_FIN:    state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:  in_ready  = 1'b1;
            S_OUT:   out_valid = 1'b1;
            default:
            begin
                in_ready  = 1'b0;
                out_valid = 1'b0;
            end
        endcase
    end

    assign calibrated_value = value_reg;
    assign divide_fault     = fault_reg;
    assign saturated        = sat_reg;

    // Datapath
    always_comb
    begin
        addr_next    = addr_reg;
        s_next       = s_reg;
        x1_next      = x1_reg;
        y1_next      = y1_reg;
        neg_next     = neg_reg;
        dsx_mag_next = dsx_mag_reg;
        dy_mag_next  = dy_mag_reg;
        dx_mag_next  = dx_mag_reg;
        prod_next    = prod_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        cnt_next     = cnt_reg;
        big_next     = big_reg;
        value_next   = value_reg;
        fault_next   = fault_reg;
        sat_next     = sat_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    s_next     = sample;
                    addr_next  = '0;
                    value_next = '0;
                    fault_next = 1'b0;
                    sat_next   = 1'b0;
                end
            end
            S_CHK0:   addr_next = cmp_lt ? LAST : '0;
            S_CHKN:   addr_next = cmp_lt ? ONE : SEG_LAST;
            S_SCAN:
            begin
                // s is already known to be at or above the previous breakpoint
                if (cmp_lt)
                    addr_next = addr_reg - ONE;
                else if (addr_reg == LAST)
                    addr_next = SEG_LAST;
                else
                    addr_next = addr_reg + ONE;
            end
            S_FETCH:
            begin
                x1_next   = x_rd;
                y1_next   = y_rd;
                addr_next = addr_reg + ONE;
            end
            S_FETCH2:
            begin
                if (x_rd == x1_reg)
                begin
                    value_next = y1_reg;
                    fault_next = 1'b1;
                end
                else
                begin
                    neg_next     = dsx[DW] ^ dy[DW] ^ dx[DW];
                    dsx_mag_next = dsx[DW] ? DW'(-dsx) : dsx[DW-1:0];
                    dy_mag_next  = dy[DW]  ? DW'(-dy)  : dy[DW-1:0];
                    dx_mag_next  = dx[DW]  ? DW'(-dx)  : dx[DW-1:0];
                end
            end
            S_MUL:    prod_next = dsx_mag_reg * dy_mag_reg;
            S_DIVI:
            begin
                // a high part at or above the divisor means the quotient overflows
                big_next = ({2'b00, prod_reg[2*DW-1:QW]} >= dx_mag_reg);
                rem_next = {2'b00, prod_reg[2*DW-1:QW]};
                dq_next  = prod_reg[QW-1:0];
                cnt_next = DIV_LAST;
            end
            S_DIV:
            begin
                rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
                dq_next  = {dq_reg[QW-2:0], ge};
                cnt_next = cnt_reg - 6'd1;
            end
            S_FIN:
            begin
                if (q_big)
                begin
                    sat_next   = 1'b1;
                    value_next = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end
                else if (sum[DW+3:DW-1] != {5{sum[DW+3]}})
                begin
                    sat_next   = 1'b1;
                    value_next = sum[DW+3] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end
                else
                begin
                    value_next = sum[DW-1:0];
                end
            end
            default:
            begin
                addr_next = addr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < POINTS; i++)
            begin
                bp_x_reg[i] <= '0;
                bp_y_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_en)
            begin
                bp_x_reg[wr_addr] <= point_x;
                bp_y_reg[wr_addr] <= point_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        s_reg       <= s_next;
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        neg_reg     <= neg_next;
        dsx_mag_reg <= dsx_mag_next;
        dy_mag_reg  <= dy_mag_next;
        dx_mag_reg  <= dx_mag_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        cnt_reg     <= cnt_next;
        big_reg     <= big_next;
        value_reg   <= value_next;
        fault_reg   <= fault_next;
        sat_reg     <= sat_next;
    end

    `PLC_ASSERT_IMPLY(a_one_side, clk, rst_n, out_valid, !in_ready,
        "ready while result held")
    `PLC_ASSERT_IMPLY(a_flags, clk, rst_n, out_valid, !(divide_fault && saturated),
        "fault and clamp both set")
    `PLC_ASSERT_NEXT(a_load_word, clk, rst_n, in_valid && in_ready && opcode == OP_LOAD,
        out_valid && calibrated_value == 32'sd0 && !divide_fault && !saturated,
        "load result not zero")
    `PLC_ASSERT_NEXT(a_map_busy, clk, rst_n, in_valid && in_ready && opcode == OP_MAP,
        !out_valid && !in_ready, "map word finished too early")

endmodule
